>>> design/bxavg_pkg.sv
// Package for the box average downscaler: widths, register map, commands and status.
// Used by every other file of the block but bxavg_div; depends on nothing.
package bxavg_pkg;

	localparam int DIMS          = 4;
	localparam int EXT_W         = 16;
	localparam int SAMPLE_W      = 16;
	localparam int FRAC_W        = 16;
	localparam int CNT_OUT_W     = 17;
	localparam int MAX_CELLS_DEF = 65536;
	// step = (extent << FRAC) / extent needs EXT+1+FRAC bits
	localparam int STEP_W        = EXT_W + 1 + FRAC_W;
	// position may run past the extent after a mid-walk register change
	localparam int POS_W         = STEP_W + EXT_W;

	localparam logic [1:0] REG_DIM_COUNT  = 2'd0;
	localparam logic [1:0] REG_SRC_EXT    = 2'd1;
	localparam logic [1:0] REG_DST_EXT    = 2'd2;
	localparam logic [1:0] REG_SMP_SIGNED = 2'd3;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_STRIDE,
		MUL_BASE,
		MUL_BACK
	} mul_op_t;

	typedef struct packed {
		logic       load_we;
		logic       div_start;
		logic       div_avg;
		logic       step_wr;
		logic       box_ld;
		mul_op_t    mul_op;
		logic       walk_rd;
		logic       out_ld;
		logic [1:0] ax;
	} cmd_t;

	typedef struct packed {
		logic origin;
		logic ax_active;
		logic div_busy;
		logic div_done;
		logic idx_over;
		logic walk_end;
		logic out_busy;
	} sts_t;

	// dimension count 0 acts as 1, above DIMS acts as DIMS
	function automatic logic [2:0] active_dims(input logic [2:0] dc);
		logic [2:0] r;
		if (dc == 3'd0)
			r = 3'd1;
		else if (dc > 3'(DIMS))
			r = 3'(DIMS);
		else
			r = dc;
		return r;
	endfunction

endpackage

>>> design/bxavg_if.sv
// Valid/ready channel interfaces for load/compute words and result words.
// Depends on bxavg_pkg.
interface bxavg_in_if;
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [bxavg_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output opcode, output sample, input ready);
	modport sink (input valid, input opcode, input sample, output ready);
endinterface

interface bxavg_out_if;
	logic                            valid;
	logic                            ready;
	logic [bxavg_pkg::SAMPLE_W-1:0]  avg_value;
	logic [bxavg_pkg::CNT_OUT_W-1:0] cells_averaged;
	logic                            last_cell;

	modport source (output valid, output avg_value, output cells_averaged, output last_cell,
		input ready);
	modport sink (input valid, input avg_value, input cells_averaged, input last_cell,
		output ready);
endinterface

>>> design/bxavg_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by bxavg_dp.
module bxavg_div #(
	parameter int DVD_W = 36,
	parameter int DSR_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   rem_sh;
	logic [DSR_W:0]   rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/bxavg_dp.sv
// Datapath: sample store, per-axis walk state, box setup multiplier, sum, divider, result word.
// Depends on bxavg_pkg and bxavg_div; driven by bxavg_ctrl commands.
module bxavg_dp #(
	parameter int MAX_CELLS = bxavg_pkg::MAX_CELLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bxavg_pkg::cmd_t                 cmd,
	output bxavg_pkg::sts_t                 sts,
	input  logic [2:0]                      dim_count,
	input  logic [63:0]                     src_ext_m1,
	input  logic [63:0]                     dst_ext_m1,
	input  logic                            smp_signed,
	input  logic [bxavg_pkg::SAMPLE_W-1:0]  sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bxavg_pkg::SAMPLE_W-1:0]  avg_value,
	output logic [bxavg_pkg::CNT_OUT_W-1:0] cells_averaged,
	output logic                            last_cell
);

	localparam int DIMS  = bxavg_pkg::DIMS;
	localparam int EW    = bxavg_pkg::EXT_W;
	localparam int SW    = bxavg_pkg::SAMPLE_W;
	localparam int FW    = bxavg_pkg::FRAC_W;
	localparam int PW    = bxavg_pkg::POS_W;
	localparam int STW   = bxavg_pkg::STEP_W;
	localparam int OCW   = bxavg_pkg::CNT_OUT_W;
	localparam int AW    = $clog2(MAX_CELLS);
	localparam int CW    = AW + 1;
	localparam int IW    = AW + 2;
	localparam int LW    = PW - FW;
	localparam int SUMW  = SW + AW + 1;
	localparam int MAGW  = SW + AW;
	localparam int DIVW  = (STW > MAGW) ? STW : MAGW;
	localparam int DSW   = (EW + 1 > CW) ? EW + 1 : CW;
	localparam int MW    = EW + 1 + CW;
	localparam logic [CW-1:0]  CAP     = CW'(MAX_CELLS);
	localparam logic [OCW-1:0] OCNT_MX = '1;

	// sample store, undefined until loaded
	logic [SW-1:0] mem_q [MAX_CELLS];
	logic [SW-1:0] rd_data_s1;
	logic          rd_pend_s1;
	logic [CW-1:0] ld_cnt_q;

	// walk state kept across items
	logic [STW-1:0] step_q [DIMS];
	logic [PW-1:0]  pos_q  [DIMS];
	logic [EW-1:0]  dest_q [DIMS];

	// per-item box
	logic [EW-1:0]  lo_q     [DIMS];
	logic [EW:0]    cnt_q    [DIMS];
	logic [EW-1:0]  off_q    [DIMS];
	logic [CW-1:0]  stride_q [DIMS];
	logic [CW-1:0]  bk_q     [DIMS];
	logic [CW-1:0]  acc_q;
	logic [IW-1:0]  idx_q;
	logic [SUMW-1:0] sum_q;
	logic [CW-1:0]  n_q;

	logic           outv_q;
	logic [SW-1:0]  avg_q;
	logic [OCW-1:0] ocnt_q;
	logic           last_q;

	logic [2:0]     d;
	logic [EW:0]    sext [DIMS];
	logic [EW:0]    dext [DIMS];
	logic [EW-1:0]  l_clip [DIMS];
	logic [EW:0]    c_box  [DIMS];
	logic           wrap [DIMS];
	logic           cin  [DIMS];
	logic           room [DIMS];
	logic [1:0]     sel;
	logic           found;
	logic [1:0]     ax_n;
	logic [EW:0]    mul_a;
	logic [CW-1:0]  mul_b;
	logic [MW-1:0]  prod;
	logic [CW-1:0]  prod_sat;
	logic [IW-1:0]  idx_sum;
	logic [CW:0]    acc_sum;
	logic [SUMW-1:0] smp_ext;
	logic [SUMW-1:0] neg_sum;
	logic [MAGW-1:0] mag;
	logic [DIVW-1:0] dvd;
	logic [DSW-1:0]  dsr;
	logic [DIVW-1:0] quo;
	logic            div_busy;
	logic            div_done;
	logic [SW-1:0]   q16;
	logic [CW+OCW-1:0] n_w;
	logic            last_c;
	logic            origin;

	assign d    = bxavg_pkg::active_dims(dim_count);
	assign ax_n = cmd.ax + 2'd1;

	// per-axis extents, box bounds, walk room and destination carry
	always_comb begin
		logic [LW-1:0] l_full;
		logic [PW:0]   ps;
		logic [LW:0]   h_full;
		logic [EW:0]   h_clip;
		origin = 1'b1;
		last_c = 1'b1;
		found  = 1'b0;
		sel    = 2'd0;
		for (int a = 0; a < DIMS; a++) begin
			sext[a]   = {1'b0, src_ext_m1[a*EW +: EW]} + (EW+1)'(1);
			dext[a]   = {1'b0, dst_ext_m1[a*EW +: EW]} + (EW+1)'(1);
			l_full    = pos_q[a][PW-1:FW];
			ps        = {1'b0, pos_q[a]} + (PW+1)'(step_q[a]);
			h_full    = ps[PW:FW];
			l_clip[a] = (l_full > LW'(sext[a] - (EW+1)'(1))) ?
				src_ext_m1[a*EW +: EW] : l_full[EW-1:0];
			h_clip    = (h_full > (LW+1)'(sext[a])) ? sext[a] : h_full[EW:0];
			c_box[a]  = (h_clip > {1'b0, l_clip[a]}) ? h_clip - {1'b0, l_clip[a]} :
				(EW+1)'(1);
			wrap[a]   = ({1'b0, dest_q[a]} + (EW+1)'(1)) >= dext[a];
			room[a]   = {1'b0, off_q[a]} != (cnt_q[a] - (EW+1)'(1));
			if (dest_q[a] != '0)
				origin = 1'b0;
			if (3'(a) < d && dest_q[a] != dst_ext_m1[a*EW +: EW])
				last_c = 1'b0;
			// innermost axis with room wins
			if (room[a]) begin
				found = 1'b1;
				sel   = 2'(a);
			end
		end
		for (int a = DIMS - 1; a >= 0; a--) begin
			if (3'(a) == d - 3'd1)
				cin[a] = 1'b1;
			else if (3'(a) < d - 3'd1)
				cin[a] = cin[a+1] & wrap[a+1];
			else
				cin[a] = 1'b0;
		end
	end

	// shared setup multiplier, saturated at the store size
	always_comb begin
		case (cmd.mul_op)
			bxavg_pkg::MUL_STRIDE: begin
				mul_a = sext[ax_n];
				mul_b = stride_q[ax_n];
			end
			bxavg_pkg::MUL_BASE: begin
				mul_a = {1'b0, lo_q[cmd.ax]};
				mul_b = stride_q[cmd.ax];
			end
			bxavg_pkg::MUL_BACK: begin
				mul_a = cnt_q[cmd.ax] - (EW+1)'(1);
				mul_b = stride_q[cmd.ax];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod     = MW'(mul_a) * MW'(mul_b);
		prod_sat = (prod > MW'(CAP)) ? CAP : prod[CW-1:0];
		idx_sum  = idx_q + IW'(prod_sat);
		acc_sum  = {1'b0, acc_q} + {1'b0, prod_sat};
	end

	always_ff @(posedge clk) begin
		if (cmd.load_we && ld_cnt_q < CAP)
			mem_q[ld_cnt_q[AW-1:0]] <= sample;
		if (cmd.walk_rd)
			rd_data_s1 <= mem_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_cnt_q   <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.walk_rd;
			if (cmd.load_we && ld_cnt_q < CAP)
				ld_cnt_q <= ld_cnt_q + CW'(1);
		end
	end

	// step, position and destination index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < DIMS; a++) begin
				step_q[a] <= '0;
				pos_q[a]  <= '0;
				dest_q[a] <= '0;
			end
		end else if (cmd.step_wr) begin
			step_q[cmd.ax] <= quo[STW-1:0];
			pos_q[cmd.ax]  <= '0;
		end else if (cmd.out_ld) begin
			for (int a = 0; a < DIMS; a++) begin
				if (cin[a]) begin
					if (wrap[a]) begin
						dest_q[a] <= '0;
						pos_q[a]  <= '0;
					end else begin
						dest_q[a] <= dest_q[a] + EW'(1);
						pos_q[a]  <= pos_q[a] + PW'(step_q[a]);
					end
				end
			end
		end
	end

	assign smp_ext = smp_signed ? {{(SUMW-SW){rd_data_s1[SW-1]}}, rd_data_s1} :
		{{(SUMW-SW){1'b0}}, rd_data_s1};

	// box setup and walk
	always_ff @(posedge clk) begin
		if (cmd.box_ld) begin
			for (int a = 0; a < DIMS; a++) begin
				lo_q[a]  <= (3'(a) < d) ? l_clip[a] : '0;
				cnt_q[a] <= (3'(a) < d) ? c_box[a] : (EW+1)'(1);
				off_q[a] <= '0;
			end
			idx_q <= '0;
			acc_q <= '0;
			sum_q <= '0;
			n_q   <= '0;
		end else begin
			case (cmd.mul_op)
				bxavg_pkg::MUL_STRIDE:
					stride_q[cmd.ax] <= ({1'b0, cmd.ax} >= d - 3'd1) ? CW'(1) : prod_sat;
				bxavg_pkg::MUL_BASE:
					idx_q <= (idx_sum > IW'(CAP)) ? IW'(CAP) : idx_sum;
				bxavg_pkg::MUL_BACK: begin
					bk_q[cmd.ax] <= acc_q;
					acc_q <= (acc_sum > (CW+1)'(CAP)) ? CAP : acc_sum[CW-1:0];
				end
				default: ;
			endcase
			if (cmd.walk_rd) begin
				n_q <= n_q + CW'(1);
				if (found) begin
					for (int a = 0; a < DIMS; a++) begin
						if (2'(a) == sel)
							off_q[a] <= off_q[a] + EW'(1);
						else if (2'(a) > sel)
							off_q[a] <= '0;
					end
					idx_q <= idx_q - IW'(bk_q[sel]) + IW'(stride_q[sel]);
				end
			end
			if (rd_pend_s1)
				sum_q <= sum_q + smp_ext;
		end
	end

	// divider operands: source extent / destination extent, or |sum| / count
	assign neg_sum = -sum_q;
	assign mag     = sum_q[SUMW-1] ? neg_sum[MAGW-1:0] : sum_q[MAGW-1:0];
	assign dvd     = cmd.div_avg ? DIVW'(mag) : DIVW'({sext[cmd.ax], {FW{1'b0}}});
	assign dsr     = cmd.div_avg ? DSW'(n_q) : DSW'(dext[cmd.ax]);

	bxavg_div #(
		.DVD_W (DIVW),
		.DSR_W (DSW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	assign q16 = quo[SW-1:0];
	assign n_w = {{OCW{1'b0}}, n_q};

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outv_q <= 1'b0;
		else if (cmd.out_ld)
			outv_q <= 1'b1;
		else if (out_ready)
			outv_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			if (n_q == '0)
				avg_q <= '0;
			else
				avg_q <= sum_q[SUMW-1] ? -q16 : q16;
			ocnt_q <= (n_w > (CW+OCW)'(OCNT_MX)) ? OCNT_MX : n_w[OCW-1:0];
			last_q <= last_c;
		end
	end

	assign out_valid      = outv_q;
	assign avg_value      = avg_q;
	assign cells_averaged = ocnt_q;
	assign last_cell      = last_q;

	assign sts.origin    = origin;
	assign sts.ax_active = {1'b0, cmd.ax} < d;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign sts.idx_over  = idx_q >= IW'(CAP);
	assign sts.walk_end  = !found;
	assign sts.out_busy  = outv_q;

endmodule

>>> design/bxavg_ctrl.sv
// Controller FSM: sequences step division, box setup, store walk, averaging and result.
// Depends on bxavg_pkg; drives bxavg_dp through cmd_t and reads sts_t.
module bxavg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_opcode,
	output logic            in_ready,
	output bxavg_pkg::cmd_t cmd,
	input  bxavg_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_STEP_GO,
		S_STEP_WAIT,
		S_BOX,
		S_STRIDE,
		S_BASE,
		S_BACK,
		S_WALK,
		S_DRAIN,
		S_AVG_GO,
		S_AVG_WAIT,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] ax_q;
	logic       acc_in;

	assign in_ready = (state_q == S_IDLE);
	assign acc_in   = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		cmd.ax     = ax_q;
		cmd.mul_op = bxavg_pkg::MUL_NONE;
		unique case (state_q)
			S_IDLE:      cmd.load_we = acc_in && (in_opcode == bxavg_pkg::OP_LOAD);
			S_STEP_GO:   cmd.div_start = sts.ax_active;
			S_STEP_WAIT: cmd.step_wr = sts.div_done;
			S_BOX:       cmd.box_ld = 1'b1;
			S_STRIDE:    cmd.mul_op = bxavg_pkg::MUL_STRIDE;
			S_BASE:      cmd.mul_op = bxavg_pkg::MUL_BASE;
			S_BACK:      cmd.mul_op = bxavg_pkg::MUL_BACK;
			S_WALK:      cmd.walk_rd = !sts.idx_over;
			S_DRAIN:     ;
			S_AVG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_avg   = 1'b1;
			end
			S_AVG_WAIT:  cmd.div_avg = 1'b1;
			S_EMIT:      cmd.out_ld = !sts.out_busy;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ax_q    <= 2'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					ax_q <= 2'(bxavg_pkg::DIMS - 1);
					if (acc_in && in_opcode == bxavg_pkg::OP_COMPUTE)
						state_q <= sts.origin ? S_STEP_GO : S_BOX;
				end
				S_STEP_GO: begin
					if (sts.ax_active)
						state_q <= S_STEP_WAIT;
					else if (ax_q == 2'd0) begin
						ax_q    <= 2'(bxavg_pkg::DIMS - 1);
						state_q <= S_BOX;
					end else
						ax_q <= ax_q - 2'd1;
				end
				S_STEP_WAIT: begin
					if (sts.div_done) begin
						if (ax_q == 2'd0) begin
							ax_q    <= 2'(bxavg_pkg::DIMS - 1);
							state_q <= S_BOX;
						end else begin
							ax_q    <= ax_q - 2'd1;
							state_q <= S_STEP_GO;
						end
					end
				end
				S_BOX:    state_q <= S_STRIDE;
				S_STRIDE: state_q <= S_BASE;
				S_BASE:   state_q <= S_BACK;
				S_BACK: begin
					if (ax_q == 2'd0)
						state_q <= S_WALK;
					else begin
						ax_q    <= ax_q - 2'd1;
						state_q <= S_STRIDE;
					end
				end
				S_WALK: begin
					if (sts.idx_over || sts.walk_end)
						state_q <= S_DRAIN;
				end
				S_DRAIN:  state_q <= S_AVG_GO;
				S_AVG_GO: state_q <= S_AVG_WAIT;
				S_AVG_WAIT: begin
					if (sts.div_done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!sts.out_busy)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register must be free when a new result is loaded
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !sts.out_busy)
		else $error("result loaded over a pending word");

	// no store read once the row-major index has left the store
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |-> !sts.idx_over)
		else $error("store read past its end");

	// divider is never restarted while running
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	// a walk read is always followed by its accumulate before the average starts
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |=> !cmd.div_start)
		else $error("average started before last sample summed");

endmodule

>>> design/box_average_downscaler_top.sv
// Top level of the box average downscaler: APB register file, controller and datapath.
// Depends on bxavg_pkg, bxavg_if, bxavg_ctrl, bxavg_dp.
//
//  channel    dir  handshake          payload
//  in_word    in   valid/ready        opcode(1), sample(16)
//  out_word   out  valid/ready        avg_value(16), cells_averaged(17), last_cell(1)
//  apb        in   psel/penable/pwrite paddr(5), pwdata(64) -> prdata(64), pready=1
//
// Load word: taken and written straight into the sample store.
// Compute word: box setup, then stride, base and back-step per axis (shared multiplier),
// then one store cell per cycle (single read port), then the DIVW-bit bit-serial divider
// (DIVW = 33 by default). The first cell of a walk adds the step divisions, one per active axis.
// Reset: registers take their reset values and the walk returns to the first cell;
// the sample store is not cleared and need not be. No clearing pass.
// Stalls: loads are accepted while a result word waits; a compute word holds at its
// end until the output register is free.
module box_average_downscaler_top #(
	parameter int MAX_CELLS = bxavg_pkg::MAX_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bxavg_in_if.sink    in_word,
	bxavg_out_if.source out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [2:0]  dim_count_q;
	logic [63:0] src_ext_q;
	logic [63:0] dst_ext_q;
	logic        smp_signed_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	bxavg_pkg::cmd_t cmd;
	bxavg_pkg::sts_t sts;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:3];  // 8-byte register slots

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q  <= 3'd2;
			src_ext_q    <= '0;
			dst_ext_q    <= '0;
			smp_signed_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				bxavg_pkg::REG_DIM_COUNT:  dim_count_q  <= pwdata[2:0];
				bxavg_pkg::REG_SRC_EXT:    src_ext_q    <= pwdata;
				bxavg_pkg::REG_DST_EXT:    dst_ext_q    <= pwdata;
				bxavg_pkg::REG_SMP_SIGNED: smp_signed_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bxavg_pkg::REG_DIM_COUNT:  prdata = {61'd0, dim_count_q};
			bxavg_pkg::REG_SRC_EXT:    prdata = src_ext_q;
			bxavg_pkg::REG_DST_EXT:    prdata = dst_ext_q;
			bxavg_pkg::REG_SMP_SIGNED: prdata = {63'd0, smp_signed_q};
			default:                   prdata = '0;
		endcase
	end

	// sequencer: one word at a time
	bxavg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_word.valid),
		.in_opcode (in_word.opcode),
		.in_ready  (in_word.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// store, walk arithmetic, divider and output register
	bxavg_dp #(
		.MAX_CELLS (MAX_CELLS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.dim_count      (dim_count_q),
		.src_ext_m1     (src_ext_q),
		.dst_ext_m1     (dst_ext_q),
		.smp_signed     (smp_signed_q),
		.sample         (in_word.sample),
		.out_valid      (out_word.valid),
		.out_ready      (out_word.ready),
		.avg_value      (out_word.avg_value),
		.cells_averaged (out_word.cells_averaged),
		.last_cell      (out_word.last_cell)
	);

endmodule
